// ----- hw/rtl/absc_pkg.sv -----
// ---------------------------------------------------------------------------
// absc_pkg: shared types and constants of the bus snoop speed control
// Holds the address map, opcodes, speed codes, register indexes and the
// request, configuration and result structures.
// ---------------------------------------------------------------------------
package absc_pkg;

    localparam int COUNT_W    = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    // Host bus address map.
    localparam logic [15:0] ADDR_PADDLE  = 16'hC070;
    localparam logic [15:0] ADDR_ROM_REL = 16'hC072;
    localparam logic [15:0] ADDR_MODE    = 16'hC074;
    localparam logic [7:0]  SLOT_IO_PAGE = 8'hC0;
    localparam logic [3:0]  SLOT_IO_LO   = 4'h9;
    localparam logic [4:0]  SLOT_ROM_TOP = 5'b11000;

    // Mode register data values.
    localparam logic [7:0] MODE_FAST    = 8'h00;
    localparam logic [7:0] MODE_ONE_MHZ = 8'h01;
    localparam logic [7:0] MODE_HALT    = 8'h03;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_TICK   = 2'd1,
        OP_RESET  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        SPEED_STOCK = 2'd0,
        SPEED_HALF  = 2'd1,
        SPEED_FULL  = 2'd2
    } speed_code_t;

    localparam logic [CFG_ADDR_W-1:0] REG_FULL_SPEED  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_EN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_MASK   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_WINDOW = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_JOY_WINDOW  = 3'd4;

    localparam logic        RST_FULL_SPEED  = 1'b1;
    localparam logic        RST_ACCEL_EN    = 1'b1;
    localparam logic [6:0]  RST_SLOT_MASK   = 7'd0;
    localparam logic [15:0] RST_SLOT_WINDOW = 16'd32;
    localparam logic [19:0] RST_JOY_WINDOW  = 20'd2816;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_addr;
        logic        is_write;
        logic [7:0]  write_data;
        logic [7:0]  tick_cycles;
    } in_item_t;

    typedef struct packed {
        logic        full_speed_select;
        logic        accel_enable;
        logic [6:0]  slot_accel_mask;
        logic [15:0] slot_window_cycles;
        logic [19:0] joy_window_cycles;
    } cfg_t;

    typedef struct packed {
        logic        swallowed;
        speed_code_t speed_code;
        logic        slow_active;
        logic        rom_passthrough;
        logic        card_halted;
    } result_t;

endpackage

// ----- hw/rtl/absc_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// absc_cfg_regs: configuration register file
// Takes register writes from the configuration channel and presents the
// current settings as one structure.
// ---------------------------------------------------------------------------
module absc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [absc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [absc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output absc_pkg::cfg_t                   cfg
);

    absc_pkg::cfg_t cfg_reg;
    absc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_addr)
                absc_pkg::REG_FULL_SPEED:  cfg_next.full_speed_select  = cfg_data[0];
                absc_pkg::REG_ACCEL_EN:    cfg_next.accel_enable       = cfg_data[0];
                absc_pkg::REG_SLOT_MASK:   cfg_next.slot_accel_mask    = cfg_data[6:0];
                absc_pkg::REG_SLOT_WINDOW: cfg_next.slot_window_cycles = cfg_data[15:0];
                absc_pkg::REG_JOY_WINDOW:  cfg_next.joy_window_cycles  = cfg_data[19:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_speed_select  <= absc_pkg::RST_FULL_SPEED;
            cfg_reg.accel_enable       <= absc_pkg::RST_ACCEL_EN;
            cfg_reg.slot_accel_mask    <= absc_pkg::RST_SLOT_MASK;
            cfg_reg.slot_window_cycles <= absc_pkg::RST_SLOT_WINDOW;
            cfg_reg.joy_window_cycles  <= absc_pkg::RST_JOY_WINDOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/absc_speed_core.sv -----
// ---------------------------------------------------------------------------
// absc_speed_core: mode state and slowdown countdown
// Decodes one registered request, updates the card state and forms the
// speed result that follows from the updated state.
// ---------------------------------------------------------------------------
module absc_speed_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  absc_pkg::in_item_t   item,
    input  absc_pkg::cfg_t       cfg,
    output absc_pkg::result_t    res
);

    logic                          one_mhz_reg;
    logic                          one_mhz_next;
    logic                          halted_reg;
    logic                          halted_next;
    logic                          pass_reg;
    logic                          pass_next;
    logic [absc_pkg::COUNT_W-1:0]  count_reg;
    logic [absc_pkg::COUNT_W-1:0]  count_next;

    logic [absc_pkg::COUNT_W-1:0]  tick_ext;
    logic                          slot_io_hit;
    logic                          slot_rom_hit;
    logic [2:0]                    slot_num;
    logic [2:0]                    slot_bit;
    logic                          slot_slows;
    logic                          swallow;

    assign tick_ext     = {{(absc_pkg::COUNT_W-8){1'b0}}, item.tick_cycles};
    // Slot I/O pages 9..F map to slots 1..7 through the low three nibble bits.
    assign slot_io_hit  = (item.bus_addr[15:8] == absc_pkg::SLOT_IO_PAGE) &&
                          (item.bus_addr[7:4] >= absc_pkg::SLOT_IO_LO);
    assign slot_rom_hit = (item.bus_addr[15:11] == absc_pkg::SLOT_ROM_TOP) &&
                          (item.bus_addr[10:8] != 3'd0);
    assign slot_num     = slot_io_hit ? item.bus_addr[6:4] : item.bus_addr[10:8];
    assign slot_bit     = slot_num - 3'd1;
    assign slot_slows   = (slot_io_hit || slot_rom_hit) && cfg.accel_enable &&
                          !cfg.slot_accel_mask[slot_bit];

    always_comb
    begin
        one_mhz_next = one_mhz_reg;
        halted_next  = halted_reg;
        pass_next    = pass_reg;
        count_next   = count_reg;
        swallow      = 1'b0;
        case (item.opcode)
            absc_pkg::OP_ACCESS:
            begin
                if (!halted_reg)
                begin
                    if (item.bus_addr == absc_pkg::ADDR_PADDLE)
                    begin
                        if (cfg.accel_enable)
                        begin
                            count_next = cfg.joy_window_cycles;
                        end
                    end
                    else if (item.is_write && item.bus_addr == absc_pkg::ADDR_ROM_REL)
                    begin
                        pass_next = 1'b1;
                    end
                    else if (item.is_write && item.bus_addr == absc_pkg::ADDR_MODE)
                    begin
                        swallow = 1'b1;
                        if (item.write_data == absc_pkg::MODE_FAST)
                        begin
                            one_mhz_next = 1'b0;
                        end
                        else if (item.write_data == absc_pkg::MODE_ONE_MHZ)
                        begin
                            one_mhz_next = 1'b1;
                        end
                        else if (item.write_data == absc_pkg::MODE_HALT)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                    else if (slot_slows)
                    begin
                        count_next = {{(absc_pkg::COUNT_W-16){1'b0}},
                                      cfg.slot_window_cycles};
                    end
                end
            end
            absc_pkg::OP_TICK:
            begin
                count_next = (count_reg > tick_ext) ? (count_reg - tick_ext) :
                             {absc_pkg::COUNT_W{1'b0}};
            end
            absc_pkg::OP_RESET:
            begin
                one_mhz_next = 1'b0;
                halted_next  = 1'b0;
                pass_next    = 1'b0;
                count_next   = {absc_pkg::COUNT_W{1'b0}};
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        res.swallowed       = swallow;
        res.slow_active     = (count_next != {absc_pkg::COUNT_W{1'b0}});
        res.rom_passthrough = pass_next;
        res.card_halted     = halted_next;
        if (halted_next || !cfg.accel_enable || one_mhz_next || res.slow_active)
        begin
            res.speed_code = absc_pkg::SPEED_STOCK;
        end
        else if (cfg.full_speed_select)
        begin
            res.speed_code = absc_pkg::SPEED_FULL;
        end
        else
        begin
            res.speed_code = absc_pkg::SPEED_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_mhz_reg <= 1'b0;
            halted_reg  <= 1'b0;
            pass_reg    <= 1'b0;
            count_reg   <= {absc_pkg::COUNT_W{1'b0}};
        end
        else if (fire)
        begin
            one_mhz_reg <= one_mhz_next;
            halted_reg  <= halted_next;
            pass_reg    <= pass_next;
            count_reg   <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.opcode == absc_pkg::OP_RESET |=>
        !one_mhz_reg && !halted_reg && !pass_reg && count_reg == '0)
        else $error("reset request left card state set");

    a_halted_no_swallow: assert property (@(posedge clk) disable iff (!rst_n)
        fire && halted_reg |-> !res.swallowed)
        else $error("request swallowed while halted");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(count_reg) && $stable(halted_reg) && $stable(one_mhz_reg))
        else $error("card state changed without a request");

    a_fast_means_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.speed_code != absc_pkg::SPEED_STOCK |=>
        count_reg == '0 && !halted_reg && !one_mhz_reg)
        else $error("accelerated speed reported with slowdown pending");
`endif

endmodule

// ----- hw/rtl/accelerator_bus_snoop_speed_control.sv -----
// ---------------------------------------------------------------------------
// accelerator_bus_snoop_speed_control: speed control of an accelerator card
// Snoops host bus requests, tracks mode and slowdown windows and reports
// the CPU speed after every request.
// ---------------------------------------------------------------------------
// Pipeline: a request goes into the input register when it is accepted and its
// result goes into the result register when it advances, which waits while m_tready is low.
// Throughput: one request per cycle while m_tready does not hold the output; the core's
// decode and countdown update sit in a single stage between the two registers.
// Reset: rst_n clears the mode flags, the countdown and the valid flags of both pipeline
// stages, and returns the configuration registers to their default values.
module accelerator_bus_snoop_speed_control (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: bus_addr[15:0], is_write[16], write_data[24:17],
    // tick_cycles[32:25], zero[39:33]
    input  logic [absc_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [absc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: swallowed[0], speed_code[2:1], slow_active[3],
    // rom_passthrough[4], card_halted[5], zero[7:6]
    output logic [absc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [absc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [absc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                             in_valid_reg;
    logic                             in_valid_next;
    absc_pkg::in_item_t               in_item_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [absc_pkg::M_TDATA_W-1:0]   out_data_reg;
    logic                             advance;
    logic                             s_fire;
    absc_pkg::cfg_t                   cfg;
    absc_pkg::result_t                res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    absc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    absc_speed_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.opcode      <= s_tuser[1:0];
            in_item_reg.bus_addr    <= s_tdata[15:0];
            in_item_reg.is_write    <= s_tdata[16];
            in_item_reg.write_data  <= s_tdata[24:17];
            in_item_reg.tick_cycles <= s_tdata[32:25];
        end
        if (advance)
        begin
            out_data_reg <= {2'b00, res.card_halted, res.rom_passthrough,
                             res.slow_active, res.speed_code, res.swallowed};
        end
    end

endmodule

// ----- test/tb_accelerator_bus_snoop_speed_control.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_accelerator_bus_snoop_speed_control: self-checking bench of the speed control
// A short table of directed requests walks the address map, the mode register
// and the special cases. Several phases of random requests follow, each under
// its own register setting. Every result is checked against a predictor of
// the card state or, for directed rows that give one, against the expected status.
// ---------------------------------------------------------------------------
module tb_accelerator_bus_snoop_speed_control;

    localparam logic [1:0]                      OP_UNUSED      = 2'd3;
    localparam logic [absc_pkg::CFG_ADDR_W-1:0] REG_UNUSED     = 3'd5;
    localparam logic [15:0]                     SLOT_IO_FIRST  = 16'hC090;
    localparam logic [15:0]                     SLOT_IO_LAST   = 16'hC0FF;
    localparam logic [15:0]                     SLOT_ROM_FIRST = 16'hC100;
    localparam logic [15:0]                     SLOT_ROM_LAST  = 16'hC7FF;
    localparam int                              PHASES         = 8;
    localparam int                              PHASE_ITEMS    = 160;
    localparam int                              STALL_LIMIT    = 3000;
    localparam absc_pkg::result_t               NO_STATUS      = '0;

    typedef struct {
        absc_pkg::in_item_t item;
        bit                 known;
        absc_pkg::result_t  want;
    } stim_row_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic [absc_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [absc_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [absc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [absc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [absc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copy of the predictor.
    logic        full_sel  = absc_pkg::RST_FULL_SPEED;
    logic        accel_en  = absc_pkg::RST_ACCEL_EN;
    logic [6:0]  slot_mask = absc_pkg::RST_SLOT_MASK;
    logic [15:0] slot_win  = absc_pkg::RST_SLOT_WINDOW;
    logic [19:0] joy_win   = absc_pkg::RST_JOY_WINDOW;

    // Card state of the predictor.
    logic        one_mhz    = 1'b0;
    logic        halted     = 1'b0;
    logic        passthru   = 1'b0;
    logic [19:0] slow_count = '0;

    absc_pkg::result_t expected_status[$];
    stim_row_t         directed_rows[$];
    int                mismatches  = 0;
    int                stall_left  = 0;
    int                quiet_count = 0;
    logic              idling      = 1'b0;

    accelerator_bus_snoop_speed_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Applies one request to the card state and returns the status it reports.
    function automatic absc_pkg::result_t predict_status(absc_pkg::in_item_t it);
        absc_pkg::result_t r;
        logic [2:0]        slot;
        logic              slot_access;
        r = NO_STATUS;
        slot = 3'd0;
        slot_access = 1'b0;
        case (it.opcode)
            absc_pkg::OP_ACCESS:
            begin
                if (!halted)
                begin
                    if (it.bus_addr == absc_pkg::ADDR_PADDLE)
                    begin
                        if (accel_en)
                            slow_count = joy_win;
                    end
                    else if (it.is_write && it.bus_addr == absc_pkg::ADDR_ROM_REL)
                        passthru = 1'b1;
                    else if (it.is_write && it.bus_addr == absc_pkg::ADDR_MODE)
                    begin
                        r.swallowed = 1'b1;
                        if (it.write_data == absc_pkg::MODE_FAST)
                            one_mhz = 1'b0;
                        else if (it.write_data == absc_pkg::MODE_ONE_MHZ)
                            one_mhz = 1'b1;
                        else if (it.write_data == absc_pkg::MODE_HALT)
                            halted = 1'b1;
                    end
                    else if (it.bus_addr >= SLOT_IO_FIRST && it.bus_addr <= SLOT_IO_LAST)
                    begin
                        slot = it.bus_addr[6:4];
                        slot_access = 1'b1;
                    end
                    else if (it.bus_addr >= SLOT_ROM_FIRST && it.bus_addr <= SLOT_ROM_LAST)
                    begin
                        slot = it.bus_addr[10:8];
                        slot_access = 1'b1;
                    end
                    // Both slot ranges only ever decode to slots 1 through 7.
                    if (slot_access && accel_en && !slot_mask[slot - 3'd1])
                        slow_count = {4'd0, slot_win};
                end
            end
            absc_pkg::OP_TICK:
                slow_count = (slow_count > it.tick_cycles) ? slow_count - it.tick_cycles : '0;
            absc_pkg::OP_RESET:
            begin
                one_mhz = 1'b0;
                halted = 1'b0;
                passthru = 1'b0;
                slow_count = '0;
            end
            default:
                ;
        endcase
        if (halted || !accel_en || one_mhz || slow_count != 0)
            r.speed_code = absc_pkg::SPEED_STOCK;
        else
            r.speed_code = full_sel ? absc_pkg::SPEED_FULL : absc_pkg::SPEED_HALF;
        r.slow_active = (slow_count != 0);
        r.rom_passthrough = passthru;
        r.card_halted = halted;
        return r;
    endfunction

    function automatic absc_pkg::in_item_t random_request();
        absc_pkg::in_item_t it;
        int                 pick;
        it.opcode = absc_pkg::OP_ACCESS;
        it.bus_addr = 16'($urandom_range(0, 16'hFFFF));
        it.is_write = 1'($urandom_range(0, 1));
        it.write_data = 8'($urandom_range(0, 8'hFF));
        it.tick_cycles = 8'($urandom_range(0, 8'hFF));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.opcode = absc_pkg::OP_TICK;
        else if (pick < 28)
            it.opcode = absc_pkg::OP_RESET;
        else if (pick < 30)
            it.opcode = OP_UNUSED;
        else
        begin
            case ($urandom_range(0, 9))
                0: it.bus_addr = absc_pkg::ADDR_PADDLE;
                1: it.bus_addr = absc_pkg::ADDR_ROM_REL;
                2:
                begin
                    it.bus_addr = absc_pkg::ADDR_MODE;
                    it.is_write = ($urandom_range(0, 3) != 0);
                    case ($urandom_range(0, 9))
                        0, 1, 2: it.write_data = absc_pkg::MODE_FAST;
                        3, 4, 5: it.write_data = absc_pkg::MODE_ONE_MHZ;
                        6:       it.write_data = absc_pkg::MODE_HALT;
                        default: ;
                    endcase
                end
                3, 4: it.bus_addr = 16'($urandom_range(SLOT_IO_FIRST, SLOT_IO_LAST));
                5, 6: it.bus_addr = 16'($urandom_range(SLOT_ROM_FIRST, SLOT_ROM_LAST));
                7:    it.bus_addr = {absc_pkg::SLOT_IO_PAGE, 8'($urandom_range(0, 8'hFF))};
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [15:0] addr, input logic wr,
                           input logic [7:0] data, input logic [7:0] ticks,
                           input bit known, input absc_pkg::result_t want);
        stim_row_t row;
        row.item = '{opcode: op, bus_addr: addr, is_write: wr, write_data: data,
                     tick_cycles: ticks};
        row.known = known;
        row.want = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Presents one request and waits for it to be taken; called at a rising edge.
    task automatic send_request(input absc_pkg::in_item_t it, input bit known,
                                input absc_pkg::result_t want);
        absc_pkg::result_t predicted;
        int                gap;
        if (idling && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.opcode;
        s_tdata <= {7'd0, it.tick_cycles, it.write_data, it.is_write, it.bus_addr};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_status(it);
        expected_status.insert(expected_status.size(), known ? want : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        // Let the two pipeline stages settle before any register write.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [absc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [absc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            absc_pkg::REG_FULL_SPEED:  full_sel = val[0];
            absc_pkg::REG_ACCEL_EN:    accel_en = val[0];
            absc_pkg::REG_SLOT_MASK:   slot_mask = val[6:0];
            absc_pkg::REG_SLOT_WINDOW: slot_win = val[15:0];
            absc_pkg::REG_JOY_WINDOW:  joy_win = val[19:0];
            default:                   ;
        endcase
    endtask

    task automatic configure_phase(input int phase);
        case (phase)
            0:
            begin
                write_reg(absc_pkg::REG_FULL_SPEED, 20'd0);
                write_reg(absc_pkg::REG_ACCEL_EN, 20'd1);
                write_reg(absc_pkg::REG_SLOT_MASK, 20'd0);
                write_reg(absc_pkg::REG_SLOT_WINDOW, 20'd0);
                write_reg(absc_pkg::REG_JOY_WINDOW, 20'd1);
            end
            1:
            begin
                write_reg(absc_pkg::REG_FULL_SPEED, 20'd1);
                write_reg(absc_pkg::REG_ACCEL_EN, 20'd0);
                write_reg(absc_pkg::REG_SLOT_MASK, 20'h7F);
                write_reg(absc_pkg::REG_SLOT_WINDOW, 20'hFFFF);
                write_reg(absc_pkg::REG_JOY_WINDOW, 20'hFFFFF);
            end
            2:
            begin
                write_reg(absc_pkg::REG_FULL_SPEED, 20'd1);
                write_reg(absc_pkg::REG_ACCEL_EN, 20'd1);
                write_reg(absc_pkg::REG_SLOT_MASK, 20'd0);
                write_reg(absc_pkg::REG_SLOT_WINDOW, 20'hFFFF);
                write_reg(absc_pkg::REG_JOY_WINDOW, 20'hFFFFF);
            end
            default:
            begin
                // Upper data bits beyond a register's width must be dropped.
                write_reg(absc_pkg::REG_FULL_SPEED, 20'($urandom_range(0, 20'hFFFFF)));
                write_reg(absc_pkg::REG_ACCEL_EN, 20'($urandom_range(0, 3) != 0));
                write_reg(absc_pkg::REG_SLOT_MASK, 20'($urandom_range(0, 20'hFFFFF)));
                write_reg(absc_pkg::REG_SLOT_WINDOW, 20'($urandom_range(0, 200)));
                write_reg(absc_pkg::REG_JOY_WINDOW, 20'($urandom_range(0, 800)));
                if (phase == 4)
                    write_reg(REG_UNUSED, 20'($urandom_range(0, 20'hFFFFF)));
            end
        endcase
    endtask

    // Result side: random back-pressure in bursts.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_status
        absc_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status 0x%02h returned with no request outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (m_tdata[0] !== want.swallowed)
                begin
                    $error("swallowed: expected %0d, got %0d", want.swallowed, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[2:1] !== want.speed_code)
                begin
                    $error("speed_code: expected %0d, got %0d", want.speed_code, m_tdata[2:1]);
                    mismatches++;
                end
                if (m_tdata[3] !== want.slow_active)
                begin
                    $error("slow_active: expected %0d, got %0d", want.slow_active, m_tdata[3]);
                    mismatches++;
                end
                if (m_tdata[4] !== want.rom_passthrough)
                begin
                    $error("rom_passthrough: expected %0d, got %0d",
                           want.rom_passthrough, m_tdata[4]);
                    mismatches++;
                end
                if (m_tdata[5] !== want.card_halted)
                begin
                    $error("card_halted: expected %0d, got %0d", want.card_halted, m_tdata[5]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling <= 1'b1;

        // Default registers: full speed, acceleration on, no slot masked,
        // slot window 32, paddle window 2816.
        add_row(absc_pkg::OP_TICK,   16'h0000,     1'b0, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b0, 1'b0});
        add_row(absc_pkg::OP_ACCESS, 16'h0000,     1'b0, 8'hFF, 8'hFF, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b0, 1'b0});
        add_row(absc_pkg::OP_ACCESS, 16'hFFFF,     1'b1, 8'hFF, 8'hFF, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b0, 1'b0});
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_PADDLE, 1'b0, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_STOCK, 1'b1, 1'b0, 1'b0});
        add_row(absc_pkg::OP_TICK,   16'h0000,     1'b0, 8'h00, 8'hFF, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_RESET,  16'h0000,     1'b0, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b0, 1'b0});
        add_row(absc_pkg::OP_ACCESS, SLOT_IO_FIRST, 1'b0, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_STOCK, 1'b1, 1'b0, 1'b0});
        // The slot window is exactly used up by a tick of the same length.
        add_row(absc_pkg::OP_TICK,   16'h0000,     1'b0, 8'h00, 8'd32, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b0, 1'b0});
        add_row(absc_pkg::OP_ACCESS, SLOT_IO_LAST,  1'b1, 8'h55, 8'h00, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_TICK,   16'h0000,     1'b0, 8'h00, 8'd31, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_TICK,   16'h0000,     1'b0, 8'h00, 8'd1,  1'b0, NO_STATUS);
        add_row(absc_pkg::OP_ACCESS, SLOT_ROM_FIRST, 1'b0, 8'h00, 8'h00, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_ACCESS, SLOT_ROM_LAST,  1'b0, 8'h00, 8'h00, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_TICK,   16'h0000,     1'b0, 8'h00, 8'hFF, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_ACCESS, 16'hC08F,     1'b1, 8'h00, 8'h00, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_ROM_REL, 1'b0, 8'h00, 8'h00, 1'b0,
                NO_STATUS);
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_ROM_REL, 1'b1, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b1, 1'b0});
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_MODE, 1'b0, absc_pkg::MODE_ONE_MHZ,
                8'h00, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_MODE, 1'b1, absc_pkg::MODE_ONE_MHZ,
                8'h00, 1'b1,
                absc_pkg::result_t'{1'b1, absc_pkg::SPEED_STOCK, 1'b0, 1'b1, 1'b0});
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_MODE, 1'b1, 8'hFF, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b1, absc_pkg::SPEED_STOCK, 1'b0, 1'b1, 1'b0});
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_MODE, 1'b1, absc_pkg::MODE_FAST,
                8'h00, 1'b1,
                absc_pkg::result_t'{1'b1, absc_pkg::SPEED_FULL, 1'b0, 1'b1, 1'b0});
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_MODE, 1'b1, absc_pkg::MODE_HALT,
                8'h00, 1'b1,
                absc_pkg::result_t'{1'b1, absc_pkg::SPEED_STOCK, 1'b0, 1'b1, 1'b1});
        // While halted every access is ignored, the mode register included.
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_PADDLE, 1'b1, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_STOCK, 1'b0, 1'b1, 1'b1});
        add_row(absc_pkg::OP_ACCESS, absc_pkg::ADDR_MODE, 1'b1, absc_pkg::MODE_FAST,
                8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_STOCK, 1'b0, 1'b1, 1'b1});
        add_row(OP_UNUSED,           16'hFFFF,     1'b1, 8'hFF, 8'hFF, 1'b0, NO_STATUS);
        add_row(absc_pkg::OP_RESET,  16'h0000,     1'b0, 8'h00, 8'h00, 1'b1,
                absc_pkg::result_t'{1'b0, absc_pkg::SPEED_FULL, 1'b0, 1'b0, 1'b0});

        for (k = 0; k < directed_rows.size(); k++)
            send_request(directed_rows[k].item, directed_rows[k].known, directed_rows[k].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            configure_phase(phase);
            idling <= (phase != 3 && phase < PHASES - 2);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(), 1'b0, NO_STATUS);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
